FILE: rtl/core/utfenc_pkg.sv
// Shared types, constants and byte-encoding functions for the UTF-16/UTF-32
// to UTF-8 encoder core. No dependencies.
package utfenc_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [31:0] CP_MAX      = 32'h0010_FFFF;
  localparam logic [20:0] CP_REPL     = 21'h00_FFFD;
  localparam logic [20:0] CP_SUPP     = 21'h01_0000;
  localparam logic [20:0] CP_ONE_MAX  = 21'h00_007F;
  localparam logic [20:0] CP_TWO_MAX  = 21'h00_07FF;
  localparam logic [20:0] CP_THREE_MAX = 21'h00_FFFF;
  localparam logic [5:0]  HIGH_SUR_TAG = 6'b110110;
  localparam logic [5:0]  LOW_SUR_TAG  = 6'b110111;
  localparam logic [20:0] SUR_BLOCK_TAG = 21'h0_001B;

  localparam logic [1:0] LEN_ONE   = 2'd0;
  localparam logic [1:0] LEN_TWO   = 2'd1;
  localparam logic [1:0] LEN_THREE = 2'd2;
  localparam logic [1:0] LEN_FOUR  = 2'd3;

  localparam logic UNIT_MODE_UTF16 = 1'b0;

  typedef struct packed {
    logic        pre;
    logic        has_cp;
    logic [20:0] cp;
    logic [1:0]  len;
  } entry_t;

  function automatic logic [20:0] sanitise(input logic [31:0] unit);
    logic [20:0] res;
    if (unit > CP_MAX || unit[31:11] == SUR_BLOCK_TAG) begin
      res = CP_REPL;
    end else begin
      res = unit[20:0];
    end
    return res;
  endfunction

  function automatic logic [1:0] cp_len(input logic [20:0] cp);
    logic [1:0] res;
    if (cp <= CP_ONE_MAX) begin
      res = LEN_ONE;
    end else if (cp <= CP_TWO_MAX) begin
      res = LEN_TWO;
    end else if (cp <= CP_THREE_MAX) begin
      res = LEN_THREE;
    end else begin
      res = LEN_FOUR;
    end
    return res;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len,
                                           input logic [1:0] idx);
    logic [7:0] res;
    logic [1:0] k;
    k = len - idx;
    if (idx == 2'd0) begin
      case (len)
        LEN_ONE:   res = {1'b0, cp[6:0]};
        LEN_TWO:   res = {3'b110, cp[10:6]};
        LEN_THREE: res = {4'b1110, cp[15:12]};
        default:   res = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (k)
        2'd1:    res = {2'b10, cp[11:6]};
        2'd2:    res = {2'b10, cp[17:12]};
        default: res = {2'b10, cp[5:0]};
      endcase
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/utfenc_if.sv
// Valid/ready channel interfaces for code units and UTF-8 bytes.
// No dependencies.
interface utfenc_unit_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

interface utfenc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

FILE: rtl/core/utfenc_front.sv
// Front end: accepts code units, tracks the held high surrogate and the mode
// register, and classifies each transaction into a queue entry. Uses utfenc_pkg.
module utfenc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  utfenc_unit_if.sink         units,
  input  logic                q_full,
  output logic                push,
  output utfenc_pkg::entry_t  push_entry
);

  logic       unit_mode;
  logic       held_valid;
  logic [9:0] held_high_bits;
  logic       held_valid_next;
  logic [9:0] held_high_bits_next;
  logic       accept;
  logic       produce;
  logic [15:0] u;
  logic       is_high;
  logic       is_low;
  logic [20:0] cp;

  assign units.ready = !q_full;
  assign accept      = units.valid && !q_full;
  assign u           = units.code_unit[15:0];
  assign is_high     = u[15:10] == utfenc_pkg::HIGH_SUR_TAG;
  assign is_low      = u[15:10] == utfenc_pkg::LOW_SUR_TAG;

  always_comb begin
    held_valid_next      = held_valid;
    held_high_bits_next  = held_high_bits;
    push_entry.pre       = 1'b0;
    push_entry.has_cp    = 1'b1;
    cp                   = utfenc_pkg::sanitise(units.code_unit);
    if (unit_mode != utfenc_pkg::UNIT_MODE_UTF16) begin
      push_entry.pre      = held_valid;
      held_valid_next     = 1'b0;
      held_high_bits_next = 10'd0;
    end else begin
      cp = utfenc_pkg::sanitise({16'd0, u});
      if (held_valid) begin
        held_valid_next     = 1'b0;
        held_high_bits_next = 10'd0;
      end
      if (held_valid && is_low) begin
        cp = utfenc_pkg::CP_SUPP + {1'b0, held_high_bits, u[9:0]};
      end else begin
        push_entry.pre = held_valid;
        if (is_high && !units.last_unit) begin
          push_entry.has_cp   = 1'b0;
          held_valid_next     = 1'b1;
          held_high_bits_next = u[9:0];
        end
      end
    end
    push_entry.cp  = cp;
    push_entry.len = utfenc_pkg::cp_len(cp);
  end

  assign produce = push_entry.pre || push_entry.has_cp;
  assign push    = accept && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_mode      <= utfenc_pkg::UNIT_MODE_UTF16;
      held_valid     <= 1'b0;
      held_high_bits <= 10'd0;
    end else begin
      if (cfg_we) begin
        unit_mode <= cfg_wdata;
      end
      if (accept) begin
        held_valid     <= held_valid_next;
        held_high_bits <= held_high_bits_next;
      end
    end
  end

endmodule

FILE: rtl/core/utfenc_queue.sv
// Short entry queue between front and back ends, first-word fall-through.
// Uses utfenc_pkg.
module utfenc_queue #(
  parameter int unsigned DEPTH = utfenc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  utfenc_pkg::entry_t push_entry,
  input  logic               pop,
  output logic               full,
  output logic               empty,
  output utfenc_pkg::entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  utfenc_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/utfenc_back.sv
// Back end: walks the head queue entry and drives one UTF-8 byte per cycle
// into the output register while the queue is not empty and the output is not stalled. Uses utfenc_pkg.
module utfenc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  utfenc_pkg::entry_t head,
  output logic               pop,
  utfenc_byte_if.source      bytes
);

  logic        in_cp;
  logic [1:0]  idx;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        advance;
  logic        phase_pre;
  logic [20:0] cur_cp;
  logic [1:0]  cur_len;
  logic        last_of_phase;
  logic        last_of_entry;

  assign phase_pre     = head.pre && !in_cp;
  assign cur_cp        = phase_pre ? utfenc_pkg::CP_REPL : head.cp;
  assign cur_len       = phase_pre ? utfenc_pkg::LEN_THREE : head.len;
  assign last_of_phase = idx == cur_len;
  assign last_of_entry = last_of_phase && (!phase_pre || !head.has_cp);
  assign advance       = !empty && (!out_valid || bytes.ready);
  assign pop           = advance && last_of_entry;

  assign bytes.valid    = out_valid;
  assign bytes.out_byte = out_byte;
  assign bytes.run_last = run_last;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= utfenc_pkg::utf8_byte(cur_cp, cur_len, idx);
      run_last <= last_of_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_cp     <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (last_of_phase) begin
          idx   <= 2'd0;
          in_cp <= !last_of_entry;
        end else begin
          idx <= idx + 2'd1;
        end
      end else if (bytes.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/utf16_utf32_to_utf8_encoder_core.sv
// UTF-16/UTF-32 to UTF-8 encoder core: front end, entry queue, back end.
// The first byte of a transaction passes through the entry queue and then the output register.
// The back end emits one output byte per cycle while the byte channel is ready; a code unit yields
// 0 to 7 bytes (4 bytes for one astral code point).
// The front takes a unit every cycle while the entry queue has room.
// Reset (synchronous): mode to UTF-16, held surrogate dropped, queue and output emptied.
module utf16_utf32_to_utf8_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = utfenc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  utfenc_unit_if.sink   unit_ch,
  utfenc_byte_if.source byte_ch
);

  logic               q_full;
  logic               q_empty;
  logic               push;
  logic               pop;
  utfenc_pkg::entry_t push_entry;
  utfenc_pkg::entry_t head;

  utfenc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .units      (unit_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  utfenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (head)
  );

  utfenc_back u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (q_empty),
    .head  (head),
    .pop   (pop),
    .bytes (byte_ch)
  );

endmodule
